>>> rtl/hrj_pkg.sv
// Shared types and constants for the homography reprojection/Jacobian pipeline.
`timescale 1ns / 1ps

package hrj_pkg;

	localparam int COORD_W       = 32;
	localparam int HOM_W         = 32;
	localparam int OUT_W         = 32;
	localparam int HOM_FRAC_BITS = 24;
	localparam int NUM_HOM       = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_W         = 32;

	// |hom * coord| >> 24 stays below 2^38; two such terms plus a small one fit 41 bits signed
	localparam int SUM_W   = 41;
	// quotient bits developed by the divider before rounding and clamping
	localparam int Q_BITS  = 33;
	// divider stages: setup, one per quotient bit, round/clamp
	localparam int DIV_STG = Q_BITS + 2;

	localparam logic [63:0] MAG_POS_LIM = 64'h0000_0000_7fff_ffff;
	localparam logic [63:0] MAG_NEG_LIM = 64'h0000_0000_8000_0000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOM_00,
		REG_HOM_01,
		REG_HOM_02,
		REG_HOM_10,
		REG_HOM_11,
		REG_HOM_12,
		REG_HOM_20,
		REG_HOM_21
	} hom_reg_t;

	localparam logic [HOM_W-1:0] HOM_RESET [NUM_HOM] = '{
		32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
		32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] meas_x;
		logic signed [COORD_W-1:0] meas_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] err_x;
		logic signed [OUT_W-1:0] err_y;
		logic signed [OUT_W-1:0] jac_x_scaled;
		logic signed [OUT_W-1:0] jac_y_scaled;
		logic signed [OUT_W-1:0] jac_recip;
		logic signed [OUT_W-1:0] jac_06;
		logic signed [OUT_W-1:0] jac_07;
		logic signed [OUT_W-1:0] jac_16;
		logic signed [OUT_W-1:0] jac_17;
		logic                    degenerate;
		logic                    overflow;
	} out_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] quot;
		logic                    ovf;
	} div_res_t;

endpackage

>>> rtl/hrj_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and clamped to 32 bits.
`timescale 1ns / 1ps

module hrj_div #(
	parameter int NUM_W = 57
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           neg,
	input  logic [NUM_W-1:0]               num,
	input  logic signed [hrj_pkg::SUM_W-1:0] den,
	output hrj_pkg::div_res_t              res
);
	import hrj_pkg::*;

	localparam int PW = SUM_W + 1;

	logic [SUM_W-1:0]  dm0;
	logic [PW-1:0]     hi0;
	logic              ovf0;

	logic [PW-1:0]     p_s   [Q_BITS+1];
	logic [Q_BITS-1:0] lo_s  [Q_BITS+1];
	logic [Q_BITS-1:0] q_s   [Q_BITS+1];
	logic [SUM_W-1:0]  dm_s  [Q_BITS+1];
	logic              neg_s [Q_BITS+1];
	logic              ovf_s [Q_BITS+1];

	logic [PW-1:0]     trial_c [Q_BITS+1];
	logic              take_c  [Q_BITS+1];

	logic              up;
	logic [Q_BITS:0]   q_rnd;
	logic [Q_BITS:0]   q_neg;
	div_res_t          res_c;
	div_res_t          res_s;

	// setup: divisor magnitude; high numerator part must stay below it or the quotient is too big
	assign dm0  = den[SUM_W-1] ? (~den + 1'b1) : den;
	assign hi0  = PW'(num[NUM_W-1:Q_BITS]);
	assign ovf0 = (hi0 >= {1'b0, dm0});

	always_comb begin
		trial_c[0] = '0;
		take_c[0]  = 1'b0;
		for (int k = 1; k <= Q_BITS; k++) begin
			trial_c[k] = {p_s[k-1][PW-2:0], lo_s[k-1][Q_BITS-1]};
			take_c[k]  = (trial_c[k] >= {1'b0, dm_s[k-1]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0]   <= hi0;
			lo_s[0]  <= num[Q_BITS-1:0];
			q_s[0]   <= '0;
			dm_s[0]  <= dm0;
			neg_s[0] <= neg ^ den[SUM_W-1];
			ovf_s[0] <= ovf0;
			for (int k = 1; k <= Q_BITS; k++) begin
				p_s[k]   <= take_c[k] ? (trial_c[k] - {1'b0, dm_s[k-1]}) : trial_c[k];
				lo_s[k]  <= {lo_s[k-1][Q_BITS-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][Q_BITS-2:0], take_c[k]};
				dm_s[k]  <= dm_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// round half away: bump when twice the remainder reaches the divisor
	assign up    = ({p_s[Q_BITS][PW-2:0], 1'b0} >= {1'b0, dm_s[Q_BITS]});
	assign q_rnd = {1'b0, q_s[Q_BITS]} + (Q_BITS+1)'(up);
	assign q_neg = ~q_rnd + 1'b1;

	always_comb begin
		res_c.ovf  = 1'b0;
		res_c.quot = q_rnd[OUT_W-1:0];
		if (neg_s[Q_BITS]) begin
			if (ovf_s[Q_BITS] || (q_rnd > (Q_BITS+1)'(MAG_NEG_LIM))) begin
				res_c.quot = OUT_MIN;
				res_c.ovf  = 1'b1;
			end else begin
				res_c.quot = q_neg[OUT_W-1:0];
			end
		end else begin
			if (ovf_s[Q_BITS] || (q_rnd > (Q_BITS+1)'(MAG_POS_LIM))) begin
				res_c.quot = OUT_MAX;
				res_c.ovf  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= res_c;
		end
	end

	assign res = res_s;

endmodule

>>> rtl/homography_reprojection_jacobian.sv
// Homography reprojection error and Jacobian, one point per beat, 40-stage pipeline.
// Throughput: one beat per cycle while the output buffer is not full. The divider develops
// one quotient bit per stage in each of its five lanes.
// A 2-entry output buffer keeps input flowing while a result waits; in_stall comes from its count.
// Reset: homography registers go to identity, valid bits and the buffer count clear.
`timescale 1ns / 1ps

module homography_reprojection_jacobian #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  hrj_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output hrj_pkg::out_beat_t             out_data,
	input  logic                           cfg_we,
	input  logic [hrj_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrj_pkg::CFG_W-1:0]      cfg_data
);
	import hrj_pkg::*;

	// numerator of px/py is |n| << F; x/w, y/w and 1/w fit below that
	localparam int NUM_W = SUM_W + COORD_FRAC_BITS;
	localparam int NSTG  = 3 + DIV_STG + 2;

	localparam logic signed [SUM_W-1:0] ONE_W = SUM_W'(1) <<< COORD_FRAC_BITS;
	localparam logic [63:0] HALF_F = 64'd1 << (COORD_FRAC_BITS - 1);
	localparam logic [1:0]  CNT_FULL = 2'd2;

	// rounded term lanes
	localparam int T_00X = 0;
	localparam int T_01Y = 1;
	localparam int T_10X = 2;
	localparam int T_11Y = 3;
	localparam int T_20X = 4;
	localparam int T_21Y = 5;
	localparam int T_02  = 6;
	localparam int T_12  = 7;
	localparam int NUM_PROD = 6;
	localparam int NUM_TERM = 8;

	// divider lanes
	localparam int L_PX = 0;
	localparam int L_PY = 1;
	localparam int L_JX = 2;
	localparam int L_JY = 3;
	localparam int L_JR = 4;
	localparam int NUM_DIV = 5;

	// Jacobian product lanes
	localparam int J_06 = 0;
	localparam int J_07 = 1;
	localparam int J_16 = 2;
	localparam int J_17 = 3;
	localparam int NUM_JAC = 4;

	typedef struct packed {
		logic signed [COORD_W-1:0] meas_x;
		logic signed [COORD_W-1:0] meas_y;
		logic                      deg;
	} side_t;

	function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
			input int unsigned sh);
		logic [63:0] m;
		m = v[63] ? (~v + 64'd1) : v;
		if (sh != 0) begin
			m = (m + (64'd1 << (sh - 1))) >> sh;
		end
		return v[63] ? -m : m;
	endfunction

	function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? (~v + 1'b1) : v;
	endfunction

	// ---------------------------------------------------------------- config
	logic signed [HOM_W-1:0] hom_q [NUM_HOM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOM; i++) begin
				hom_q[i] <= HOM_RESET[i];
			end
		end else if (cfg_we) begin
			hom_q[cfg_index] <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- flow control
	// The whole pipe moves together; it only halts when the output buffer holds two beats.
	logic              adv;
	logic [NSTG-1:0]   vld_s;
	logic [1:0]        cnt_q;
	logic              push;
	logic              pop;

	assign adv      = (cnt_q != CNT_FULL);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], in_valid};
		end
	end

	// ---------------------------------------------------------------- s1: products
	logic signed [63:0] prod_s1 [NUM_PROD];
	in_beat_t           pt_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[T_00X] <= hom_q[REG_HOM_00] * in_data.point_x;
			prod_s1[T_01Y] <= hom_q[REG_HOM_01] * in_data.point_y;
			prod_s1[T_10X] <= hom_q[REG_HOM_10] * in_data.point_x;
			prod_s1[T_11Y] <= hom_q[REG_HOM_11] * in_data.point_y;
			prod_s1[T_20X] <= hom_q[REG_HOM_20] * in_data.point_x;
			prod_s1[T_21Y] <= hom_q[REG_HOM_21] * in_data.point_y;
			pt_s1          <= in_data;
		end
	end

	// ---------------------------------------------------------------- s2: round terms
	// products drop 24 fraction bits; translations drop 24-F
	logic signed [SUM_W-1:0] term_c  [NUM_TERM];
	logic signed [SUM_W-1:0] term_s2 [NUM_TERM];
	in_beat_t                pt_s2;

	always_comb begin
		for (int i = 0; i < NUM_PROD; i++) begin
			term_c[i] = SUM_W'(round_away(prod_s1[i], HOM_FRAC_BITS));
		end
		term_c[T_02] = SUM_W'(round_away(64'(hom_q[REG_HOM_02]),
			HOM_FRAC_BITS - COORD_FRAC_BITS));
		term_c[T_12] = SUM_W'(round_away(64'(hom_q[REG_HOM_12]),
			HOM_FRAC_BITS - COORD_FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s2 <= term_c;
			pt_s2   <= pt_s1;
		end
	end

	// ---------------------------------------------------------------- s3: sums
	logic signed [SUM_W-1:0] w_c;
	logic signed [SUM_W-1:0] w_s3;
	logic signed [SUM_W-1:0] nx_s3;
	logic signed [SUM_W-1:0] ny_s3;
	logic                    deg_s3;
	in_beat_t                pt_s3;

	assign w_c = term_s2[T_20X] + term_s2[T_21Y] + ONE_W;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3   <= w_c;
			nx_s3  <= term_s2[T_00X] + term_s2[T_01Y] + term_s2[T_02];
			ny_s3  <= term_s2[T_10X] + term_s2[T_11Y] + term_s2[T_12];
			deg_s3 <= (w_c == '0);
			pt_s3  <= pt_s2;
		end
	end

	// ---------------------------------------------------------------- s4..s38: dividers
	logic             div_neg [NUM_DIV];
	logic [NUM_W-1:0] div_num [NUM_DIV];
	div_res_t         div_res [NUM_DIV];
	logic [COORD_W-1:0] xmag;
	logic [COORD_W-1:0] ymag;

	assign xmag = pt_s3.point_x[COORD_W-1] ? (~pt_s3.point_x + 1'b1) : pt_s3.point_x;
	assign ymag = pt_s3.point_y[COORD_W-1] ? (~pt_s3.point_y + 1'b1) : pt_s3.point_y;

	always_comb begin
		div_neg[L_PX] = nx_s3[SUM_W-1];
		div_num[L_PX] = NUM_W'(mag_sum(nx_s3)) << COORD_FRAC_BITS;
		div_neg[L_PY] = ny_s3[SUM_W-1];
		div_num[L_PY] = NUM_W'(mag_sum(ny_s3)) << COORD_FRAC_BITS;
		div_neg[L_JX] = pt_s3.point_x[COORD_W-1];
		div_num[L_JX] = NUM_W'(xmag) << COORD_FRAC_BITS;
		div_neg[L_JY] = pt_s3.point_y[COORD_W-1];
		div_num[L_JY] = NUM_W'(ymag) << COORD_FRAC_BITS;
		div_neg[L_JR] = 1'b0;
		div_num[L_JR] = NUM_W'(1) << (2 * COORD_FRAC_BITS);
	end

	for (genvar l = 0; l < NUM_DIV; l++) begin : g_div
		hrj_div #(
			.NUM_W (NUM_W)
		) u_div (
			.clk (clk),
			.en  (adv),
			.neg (div_neg[l]),
			.num (div_num[l]),
			.den (w_s3),
			.res (div_res[l])
		);
	end

	// measurements and the zero-denominator flag ride alongside the divider
	side_t side_s [DIV_STG];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= '{meas_x: pt_s3.meas_x, meas_y: pt_s3.meas_y, deg: deg_s3};
			for (int k = 1; k < DIV_STG; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- s39: Jacobian products
	// zero denominator: quotients forced to 0, so products and error follow from that
	logic signed [OUT_W-1:0] qm_c [NUM_DIV];
	logic                    dov_c;
	logic signed [OUT_W-1:0] q_s39 [NUM_DIV];
	logic signed [63:0]      jp_s39 [NUM_JAC];
	side_t                   side_s39;
	logic                    dov_s39;

	always_comb begin
		dov_c = 1'b0;
		for (int l = 0; l < NUM_DIV; l++) begin
			qm_c[l] = side_s[DIV_STG-1].deg ? '0 : div_res[l].quot;
			dov_c   = dov_c | div_res[l].ovf;
		end
		dov_c = dov_c & !side_s[DIV_STG-1].deg;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s39          <= qm_c;
			jp_s39[J_06]   <= qm_c[L_JX] * qm_c[L_PX];
			jp_s39[J_07]   <= qm_c[L_JY] * qm_c[L_PX];
			jp_s39[J_16]   <= qm_c[L_JX] * qm_c[L_PY];
			jp_s39[J_17]   <= qm_c[L_JY] * qm_c[L_PY];
			side_s39       <= side_s[DIV_STG-1];
			dov_s39        <= dov_c;
		end
	end

	// ---------------------------------------------------------------- s40: round magnitudes
	logic [63:0]             jabs_c [NUM_JAC];
	logic [63:0]             jmag_s40 [NUM_JAC];
	logic                    jneg_s40 [NUM_JAC];
	logic signed [OUT_W-1:0] q_s40 [NUM_DIV];
	side_t                   side_s40;
	logic                    dov_s40;

	always_comb begin
		for (int j = 0; j < NUM_JAC; j++) begin
			jabs_c[j] = jp_s39[j][63] ? (~jp_s39[j] + 64'd1) : jp_s39[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NUM_JAC; j++) begin
				jmag_s40[j] <= (jabs_c[j] + HALF_F) >> COORD_FRAC_BITS;
				jneg_s40[j] <= jp_s39[j][63];
			end
			q_s40    <= q_s39;
			side_s40 <= side_s39;
			dov_s40  <= dov_s39;
		end
	end

	// ---------------------------------------------------------------- negate, clamp, error
	logic signed [OUT_W-1:0] jval_c [NUM_JAC];
	logic                    jov_c  [NUM_JAC];
	logic [63:0]             jinv_c [NUM_JAC];
	logic signed [OUT_W:0]   ex_c;
	logic signed [OUT_W:0]   ey_c;
	logic signed [OUT_W-1:0] exs_c;
	logic signed [OUT_W-1:0] eys_c;
	logic                    exov_c;
	logic                    eyov_c;
	logic                    any_jov_c;
	out_beat_t               beat_c;

	always_comb begin
		any_jov_c = 1'b0;
		for (int j = 0; j < NUM_JAC; j++) begin
			jinv_c[j] = ~jmag_s40[j] + 64'd1;
			jov_c[j]  = 1'b0;
			// negative product turns positive after the minus sign
			if (jneg_s40[j]) begin
				if (jmag_s40[j] > MAG_POS_LIM) begin
					jval_c[j] = OUT_MAX;
					jov_c[j]  = 1'b1;
				end else begin
					jval_c[j] = jmag_s40[j][OUT_W-1:0];
				end
			end else begin
				if (jmag_s40[j] > MAG_NEG_LIM) begin
					jval_c[j] = OUT_MIN;
					jov_c[j]  = 1'b1;
				end else begin
					jval_c[j] = jinv_c[j][OUT_W-1:0];
				end
			end
			any_jov_c = any_jov_c | jov_c[j];
		end

		ex_c = {q_s40[L_PX][OUT_W-1], q_s40[L_PX]}
			- {side_s40.meas_x[COORD_W-1], side_s40.meas_x};
		ey_c = {q_s40[L_PY][OUT_W-1], q_s40[L_PY]}
			- {side_s40.meas_y[COORD_W-1], side_s40.meas_y};
		exov_c = (ex_c[OUT_W] != ex_c[OUT_W-1]);
		eyov_c = (ey_c[OUT_W] != ey_c[OUT_W-1]);
		exs_c  = exov_c ? (ex_c[OUT_W] ? OUT_MIN : OUT_MAX) : ex_c[OUT_W-1:0];
		eys_c  = eyov_c ? (ey_c[OUT_W] ? OUT_MIN : OUT_MAX) : ey_c[OUT_W-1:0];

		beat_c.err_x        = exs_c;
		beat_c.err_y        = eys_c;
		beat_c.jac_x_scaled = q_s40[L_JX];
		beat_c.jac_y_scaled = q_s40[L_JY];
		beat_c.jac_recip    = q_s40[L_JR];
		beat_c.jac_06       = jval_c[J_06];
		beat_c.jac_07       = jval_c[J_07];
		beat_c.jac_16       = jval_c[J_16];
		beat_c.jac_17       = jval_c[J_17];
		beat_c.degenerate   = side_s40.deg;
		beat_c.overflow     = dov_s40 | any_jov_c | exov_c | eyov_c;
	end

	// ---------------------------------------------------------------- output buffer
	// head_q is what the port shows; spare_q catches the beat that lands while head is stalled
	out_beat_t head_q;
	out_beat_t spare_q;

	assign push      = adv & vld_s[NSTG-1];
	assign pop       = (cnt_q != 2'd0) & !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (cnt_q == CNT_FULL)) begin
			head_q <= spare_q;
		end else if (push && ((cnt_q == 2'd0) || pop)) begin
			head_q <= beat_c;
		end
		if (push && !pop && (cnt_q == 2'd1)) begin
			spare_q <= beat_c;
		end
	end

endmodule

>>> dv/homography_reprojection_jacobian_test.sv
// Self-checking testbench for the homography reprojection error and Jacobian pipeline.
`timescale 1ns / 1ps

module homography_reprojection_jacobian_test;
	import hrj_pkg::*;

	localparam int FRAC          = 16;
	localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
	localparam int DRAIN_CYCLES  = 50;    // pipeline is 40 deep
	localparam int PHASE_POINTS  = 75;
	localparam int RANDOM_PHASES = 8;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	localparam logic [31:0] HOM_ONE     = 32'h0100_0000;  // 1.0 in Q8.24
	localparam logic [31:0] HOM_NEG_ONE = 32'hFF00_0000;  // -1.0 in Q8.24
	localparam logic [31:0] COORD_ONE   = 32'h0001_0000;  // 1.0 in Q16.16

	// how often each side idles or stalls
	typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;
	// flavor of homography loaded for a random phase
	typedef enum int {HOM_MILD, HOM_WILD, HOM_ZERO_W, HOM_EXTREME} hom_mix_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_beat_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	in_beat_t         pending_points[$];    // beats not yet offered to the block
	out_beat_t        awaited_results[$];   // predicted results, oldest first
	logic [HOM_W-1:0] hom_regs [NUM_HOM];   // our copy of the homography registers
	logic [HOM_W-1:0] hom_next [NUM_HOM];   // values for the next register load
	pace_t            pace         = PACE_FULL;
	int               gap_left     = 0;
	int               stall_left   = 0;
	int               quiet_cycles = 0;
	int               mismatches   = 0;

	homography_reprojection_jacobian #(
		.COORD_FRAC_BITS(FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- arithmetic

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// shift right by s with rounding half away from zero
	function automatic longint round_half_away(longint v, int s);
		longint m;
		m = (v < 0) ? -v : v;
		if (s == 0)
			return v;
		m = (m + (longint'(1) << (s - 1))) >> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clamp32(longint v, inout bit ovf);
		if (v > S32_MAX) begin
			ovf = 1'b1;
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			ovf = 1'b1;
			return S32_MIN;
		end
		return v;
	endfunction

	// signed quotient of (sign, magnitude) by den, rounded half away, clamped to 32 bits
	function automatic longint div_round_clamp(bit num_neg, longint unsigned num_mag,
			longint den, inout bit ovf);
		longint unsigned den_mag, q, r;
		bit neg;
		den_mag = magnitude(den);
		q = num_mag / den_mag;
		r = num_mag % den_mag;
		neg = num_neg ^ (den < 0);
		if (r >= den_mag - r)
			q++;
		if (!neg) begin
			if (q > 64'd2147483647) begin
				ovf = 1'b1;
				return S32_MAX;
			end
			return longint'(q);
		end
		if (q > 64'd2147483648) begin
			ovf = 1'b1;
			return S32_MIN;
		end
		return -longint'(q);
	endfunction

	// hom entry times a coordinate, back to coordinate precision
	function automatic longint hom_term(hom_reg_t idx, longint v);
		return round_half_away(longint'($signed(hom_regs[idx])) * v, HOM_FRAC_BITS);
	endfunction

	function automatic longint neg_product(longint a, longint b, inout bit ovf);
		return clamp32(-round_half_away(a * b, FRAC), ovf);
	endfunction

	// projects one point through the current homography: error plus Jacobian entries
	function automatic out_beat_t reproject(in_beat_t b);
		longint x, y, w, nx, ny;
		longint px, py, jx, jy, jr, j06, j07, j16, j17, ex, ey;
		bit ovf;
		out_beat_t r;
		x = $signed(b.point_x);
		y = $signed(b.point_y);
		ovf = 1'b0;
		px = 0; py = 0; jx = 0; jy = 0; jr = 0;
		j06 = 0; j07 = 0; j16 = 0; j17 = 0;
		w  = hom_term(REG_HOM_20, x) + hom_term(REG_HOM_21, y) + (longint'(1) << FRAC);
		nx = hom_term(REG_HOM_00, x) + hom_term(REG_HOM_01, y)
			+ round_half_away(longint'($signed(hom_regs[REG_HOM_02])), HOM_FRAC_BITS - FRAC);
		ny = hom_term(REG_HOM_10, x) + hom_term(REG_HOM_11, y)
			+ round_half_away(longint'($signed(hom_regs[REG_HOM_12])), HOM_FRAC_BITS - FRAC);
		// zero denominator: everything derived from 1/w stays zero, px = py = 0
		if (w != 0) begin
			px  = div_round_clamp(nx < 0, magnitude(nx) << FRAC, w, ovf);
			py  = div_round_clamp(ny < 0, magnitude(ny) << FRAC, w, ovf);
			jx  = div_round_clamp(x < 0, magnitude(x) << FRAC, w, ovf);
			jy  = div_round_clamp(y < 0, magnitude(y) << FRAC, w, ovf);
			jr  = div_round_clamp(1'b0, 64'd1 << (2 * FRAC), w, ovf);
			j06 = neg_product(jx, px, ovf);
			j07 = neg_product(jy, px, ovf);
			j16 = neg_product(jx, py, ovf);
			j17 = neg_product(jy, py, ovf);
		end
		ex = clamp32(px - longint'($signed(b.meas_x)), ovf);
		ey = clamp32(py - longint'($signed(b.meas_y)), ovf);
		r.err_x        = ex[31:0];
		r.err_y        = ey[31:0];
		r.jac_x_scaled = jx[31:0];
		r.jac_y_scaled = jy[31:0];
		r.jac_recip    = jr[31:0];
		r.jac_06       = j06[31:0];
		r.jac_07       = j07[31:0];
		r.jac_16       = j16[31:0];
		r.jac_17       = j17[31:0];
		r.degenerate   = (w == 0);
		r.overflow     = ovf;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// gap or stall length; mostly short, now and then long
	function automatic int pick_gap(pace_t mode);
		int roll;
		roll = $urandom_range(0, 99);
		if (mode == PACE_FULL)
			return 0;
		if (roll < ((mode == PACE_LIGHT) ? 75 : 40))
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// uniform in [-2^bits, 2^bits]
	function automatic logic [31:0] signed_spread(int bits);
		return $urandom_range(0, 2 * (1 << bits)) - (1 << bits);
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] corner_values [7];
		int roll;
		corner_values = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, COORD_ONE,
			32'hffff_0000, 32'h1, 32'hffff_ffff};
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return signed_spread(22);  // within +-64: outputs mostly in range
		if (roll < 65)
			return signed_spread(28);
		if (roll < 90)
			return $urandom;
		return corner_values[$urandom_range(0, 6)];
	endfunction

	task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] mx,
			logic [31:0] my);
		in_beat_t b;
		b.point_x = x;
		b.point_y = y;
		b.meas_x  = mx;
		b.meas_y  = my;
		pending_points.push_back(b);
	endtask

	task automatic queue_random_point(hom_mix_t mix);
		in_beat_t b;
		b.point_x = rand_coord();
		b.point_y = rand_coord();
		b.meas_x  = rand_coord();
		b.meas_y  = rand_coord();
		// with hom_20 = -1 and a tiny hom_21, x near 1.0 and a small y drive w to zero or one LSB
		if (mix == HOM_ZERO_W && $urandom_range(0, 9) < 4) begin
			b.point_x = COORD_ONE + $urandom_range(0, 2) - 1;
			b.point_y = $urandom_range(0, 510) - 255;
		end
		pending_points.push_back(b);
	endtask

	task automatic make_homography(hom_mix_t mix);
		logic [HOM_W-1:0] picks [5];
		picks = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, HOM_ONE, HOM_NEG_ONE};
		case (mix)
			HOM_WILD: begin
				for (int i = 0; i < NUM_HOM; i++)
					hom_next[i] = $urandom;
			end
			HOM_EXTREME: begin
				for (int i = 0; i < NUM_HOM; i++)
					hom_next[i] = picks[$urandom_range(0, 4)];
			end
			default: begin
				// near identity, modest translation, small perspective
				hom_next[REG_HOM_00] = HOM_ONE + signed_spread(23);
				hom_next[REG_HOM_01] = signed_spread(23);
				hom_next[REG_HOM_02] = signed_spread(28);
				hom_next[REG_HOM_10] = signed_spread(23);
				hom_next[REG_HOM_11] = HOM_ONE + signed_spread(23);
				hom_next[REG_HOM_12] = signed_spread(28);
				hom_next[REG_HOM_20] = signed_spread(14);
				hom_next[REG_HOM_21] = signed_spread(14);
				if (mix == HOM_ZERO_W)
					hom_next[REG_HOM_20] = HOM_NEG_ONE;
			end
		endcase
	endtask

	// writes all eight registers back to back; only called with the block idle
	task automatic load_homography();
		for (int i = 0; i < NUM_HOM; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= hom_reg_t'(i);
			cfg_data  <= hom_next[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// sender holds off until every beat is in and every result is back
	task automatic settle();
		do begin
			@(negedge clk);
		end while (pending_points.size() != 0 || in_valid || awaited_results.size() != 0);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic compare_result(out_beat_t want, out_beat_t got);
		check_field("err_x", want.err_x, got.err_x);
		check_field("err_y", want.err_y, got.err_y);
		check_field("jac_x_scaled", want.jac_x_scaled, got.jac_x_scaled);
		check_field("jac_y_scaled", want.jac_y_scaled, got.jac_y_scaled);
		check_field("jac_recip", want.jac_recip, got.jac_recip);
		check_field("jac_06", want.jac_06, got.jac_06);
		check_field("jac_07", want.jac_07, got.jac_07);
		check_field("jac_16", want.jac_16, got.jac_16);
		check_field("jac_17", want.jac_17, got.jac_17);
		check_field("degenerate", want.degenerate, got.degenerate);
		check_field("overflow", want.overflow, got.overflow);
	endtask

	// ---------------------------------------------------------------- clocked processes

	// register copy follows the write port exactly as the block does
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOM; i++)
				hom_regs[i] <= HOM_RESET[i];
		end else if (cfg_we) begin
			hom_regs[cfg_index] <= cfg_data;
		end
	end

	// input driver: a stalled beat holds; a new one goes out after its gap
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				in_data  <= pending_points.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_gap(pace);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// every accepted beat gets its prediction, computed with the registers it saw
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			awaited_results.push_back(reproject(in_data));
	end

	// output side: random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_left == 0)
				stall_left = pick_gap(pace);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// monitor: each accepted result against the oldest prediction
	always @(posedge clk) begin : sample_result
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual %h", $time, out_data);
			end else begin
				want = awaited_results.pop_front();
				compare_result(want, out_data);
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("homography_reprojection_jacobian_test failed");
		$finish;
	end

	// ---------------------------------------------------------------- test sequence

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity from reset: w = 1, error is plain subtraction, products of large points saturate
		queue_point(32'h0, 32'h0, 32'h0, 32'h0);
		queue_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		queue_point(COORD_ONE, 32'hffff_0000, 32'h0000_8000, 32'hffff_8000);
		queue_point(32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
		queue_point(32'h1, 32'hffff_ffff, 32'h0, 32'h0);
		settle();

		// extreme entries with hom_20 = -1: x = 1.0 gives a zero denominator,
		// one LSB either side gives a tiny w and saturated quotients
		hom_next = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, HOM_NEG_ONE, 32'h0};
		load_homography();
		pace = PACE_LIGHT;
		queue_point(COORD_ONE, 32'h0, 32'h0, 32'h0);
		queue_point(COORD_ONE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		queue_point(32'h0, 32'h0, 32'h0, 32'h0);
		queue_point(32'h0001_0001, 32'h0, 32'h1234_5678, 32'h0);
		queue_point(32'h0000_ffff, 32'h0, 32'h0, 32'hedcb_a988);
		queue_point(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		queue_point(32'h0000_8000, 32'h0, 32'h0, 32'h0);
		settle();

		// exact half-LSB terms: rounding must go away from zero in both signs
		hom_next = '{HOM_ONE, 32'h0080_0000, 32'h0000_0180, 32'h0,
			HOM_ONE, 32'hffff_fe80, 32'h0000_0080, 32'hffff_ff80};
		load_homography();
		pace = PACE_HEAVY;
		queue_point(32'h0, 32'h1, 32'h0, 32'h0);
		queue_point(32'h0, 32'hffff_ffff, 32'h0, 32'h0);
		queue_point(COORD_ONE, COORD_ONE, 32'h0000_8000, 32'hffff_8000);
		queue_point(32'h0003_0000, 32'hfffd_0000, 32'h0, 32'h0);
		settle();

		// random phases: each a fresh homography and pace, drained before the next load
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			make_homography(hom_mix_t'(p % 4));
			load_homography();
			pace = pace_t'(p % 3);
			for (int n = 0; n < PHASE_POINTS; n++)
				queue_random_point(hom_mix_t'(p % 4));
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("homography_reprojection_jacobian_test passed");
		else
			$display("homography_reprojection_jacobian_test failed");
		$finish;
	end

endmodule
